// ===== rtl/rrc_pkg.sv =====
package rrc_pkg;

    // Value width of a numerator; a denominator is one bit narrower.
    localparam int W        = 32;
    localparam int KW       = $clog2(W);
    // Binary gcd steps: each one drops at least one bit from the pair.
    localparam int NG       = 2 * W;
    localparam int IN_BITS  = ((4 * W - 2 + 7) / 8) * 8;
    localparam int OUT_BITS = ((2 * W + 1 + 7) / 8) * 8;

    localparam logic ACT_REDUCE  = 1'b0;
    localparam logic ACT_COMPARE = 1'b1;

    // One item inside the gcd pipeline.
    typedef struct packed {
        logic          action;
        logic          neg;
        logic          gt;
        logic          eq;
        logic [W-1:0]  mag;
        logic [W-1:0]  den;
        logic [W-1:0]  u;
        logic [W-1:0]  v;
        logic [KW-1:0] k;
    } gcd_item_t;

    // One item inside the division pipeline.
    typedef struct packed {
        logic         action;
        logic         neg;
        logic         gt;
        logic         eq;
        logic [W-1:0] g;
        logic [W-1:0] rem_n;
        logic [W-1:0] q_n;
        logic [W-1:0] rem_d;
        logic [W-1:0] q_d;
    } div_item_t;

    // One step of the binary gcd; a finished pair is left as it is.
    function automatic gcd_item_t gcd_step(input gcd_item_t x);
        gcd_item_t y;
        y = x;
        if ((x.u != '0) && (x.v != '0))
        begin
            if (!x.u[0] && !x.v[0])
            begin
                y.u = x.u >> 1;
                y.v = x.v >> 1;
                y.k = x.k + KW'(1);
            end
            else if (!x.u[0])
            begin
                y.u = x.u >> 1;
            end
            else if (!x.v[0])
            begin
                y.v = x.v >> 1;
            end
            else if (x.u >= x.v)
            begin
                y.u = (x.u - x.v) >> 1;
            end
            else
            begin
                y.v = (x.v - x.u) >> 1;
            end
        end
        return y;
    endfunction

    // One restoring division step for both the numerator and the denominator.
    function automatic div_item_t div_step(input div_item_t x);
        div_item_t    y;
        logic [W-1:0] tn;
        logic [W-1:0] td;
        y  = x;
        tn = {x.rem_n[W-2:0], x.q_n[W-1]};
        td = {x.rem_d[W-2:0], x.q_d[W-1]};
        if (tn >= x.g)
        begin
            y.rem_n = tn - x.g;
            y.q_n   = {x.q_n[W-2:0], 1'b1};
        end
        else
        begin
            y.rem_n = tn;
            y.q_n   = {x.q_n[W-2:0], 1'b0};
        end
        if (td >= x.g)
        begin
            y.rem_d = td - x.g;
            y.q_d   = {x.q_d[W-2:0], 1'b1};
        end
        else
        begin
            y.rem_d = td;
            y.q_d   = {x.q_d[W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

// ===== rtl/rational_reduce_and_compare.sv =====
// Throughput: one transaction per cycle while the output is not stalled; the 64-stage gcd
// pipeline takes one step per stage, and the division pipeline has a start stage and 32 step stages.
// A stalled output freezes every stage, so nothing is lost or repeated.
// Reset (rst_n, asynchronous, active low) clears all stage valid bits;
// the block accepts input in the first cycle after reset.
module rational_reduce_and_compare
    import rrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // num_a, den_a, num_b, den_b, zero pad
    input  logic [IN_BITS-1:0]  s_tdata,
    // action
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // reduced_num, reduced_den, is_greater, is_equal, zero pad
    output logic [OUT_BITS-1:0] m_tdata
);

    logic                  advance;
    logic signed [W-1:0]   num_a;
    logic        [W-2:0]   den_a;
    logic signed [W-1:0]   num_b;
    logic        [W-2:0]   den_b;
    logic        [W-2:0]   da_fix;
    logic        [W-2:0]   db_fix;
    logic signed [W-1:0]   da_s;
    logic signed [W-1:0]   db_s;
    logic signed [2*W-1:0] lhs_next;
    logic signed [2*W-1:0] rhs_next;

    logic                  a_valid_reg;
    logic                  a_action_reg;
    logic        [W-1:0]   a_num_reg;
    logic        [W-2:0]   a_den_reg;
    logic signed [2*W-1:0] a_lhs_reg;
    logic signed [2*W-1:0] a_rhs_reg;

    logic                  b_valid_reg;
    gcd_item_t             b_item_reg;
    gcd_item_t             b_item_next;

    logic                  gcd_valid;
    gcd_item_t             gcd_item;
    div_item_t             div_init;

    logic                  dv_reg [W+1];
    div_item_t             div_reg [W+1];
    div_item_t             last;
    logic        [W-1:0]   rn;

    // The whole pipeline moves unless a finished result is held back.
    assign advance  = !dv_reg[W] || m_tready;
    assign s_tready = advance;

    // Unpack the input transaction; a zero denominator counts as one.
    assign num_a  = s_tdata[W-1:0];
    assign den_a  = s_tdata[2*W-2:W];
    assign num_b  = s_tdata[3*W-2:2*W-1];
    assign den_b  = s_tdata[4*W-3:3*W-1];
    assign da_fix = (den_a == '0) ? (W-1)'(1) : den_a;
    assign db_fix = (den_b == '0) ? (W-1)'(1) : den_b;
    assign da_s   = {1'b0, da_fix};
    assign db_s   = {1'b0, db_fix};

    // Cross products for the compare.
    assign lhs_next = num_a * db_s;
    assign rhs_next = num_b * da_s;

    // Stage A: input register with the products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_action_reg <= s_tuser;
            a_num_reg    <= num_a;
            a_den_reg    <= da_fix;
            a_lhs_reg    <= lhs_next;
            a_rhs_reg    <= rhs_next;
        end
    end

    // Stage B: compare flags, magnitude and the gcd start pair.
    always_comb
    begin
        b_item_next.action = a_action_reg;
        b_item_next.neg    = a_num_reg[W-1];
        b_item_next.mag    = a_num_reg[W-1] ? (W)'(-a_num_reg) : a_num_reg;
        b_item_next.den    = {1'b0, a_den_reg};
        b_item_next.u      = b_item_next.mag;
        b_item_next.v      = b_item_next.den;
        b_item_next.k      = '0;
        b_item_next.gt     = a_lhs_reg > a_rhs_reg;
        b_item_next.eq     = a_lhs_reg == a_rhs_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_item_reg <= b_item_next;
        end
    end

    rrc_gcd u_gcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (b_valid_reg),
        .in_item   (b_item_reg),
        .out_valid (gcd_valid),
        .out_item  (gcd_item)
    );

    // Division start: gcd is the odd part shifted back by the common twos.
    always_comb
    begin
        div_init.action = gcd_item.action;
        div_init.neg    = gcd_item.neg;
        div_init.gt     = gcd_item.gt;
        div_init.eq     = gcd_item.eq;
        div_init.g      = (gcd_item.u | gcd_item.v) << gcd_item.k;
        div_init.rem_n  = '0;
        div_init.q_n    = gcd_item.mag;
        div_init.rem_d  = '0;
        div_init.q_d    = gcd_item.den;
    end

    // Division stages, one quotient bit each.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= W; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            dv_reg[0] <= gcd_valid;
            for (int i = 1; i <= W; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_reg[0] <= div_init;
            for (int i = 1; i <= W; i++)
            begin
                div_reg[i] <= div_step(div_reg[i-1]);
            end
        end
    end

    // Result transaction: reduce fills the fraction, compare fills the flags.
    assign last     = div_reg[W];
    assign rn       = last.neg ? (W)'(-last.q_n) : last.q_n;
    assign m_tvalid = dv_reg[W];

    always_comb
    begin
        m_tdata = '0;
        if (last.action == ACT_COMPARE)
        begin
            m_tdata[2*W-1] = last.gt;
            m_tdata[2*W]   = last.eq;
        end
        else
        begin
            m_tdata[W-1:0]   = rn;
            m_tdata[2*W-2:W] = last.q_d[W-2:0];
        end
    end

`ifndef NO_ASSERTIONS
    // Division by the gcd is exact for both terms.
    a_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (last.action == ACT_REDUCE))
            |-> ((last.rem_n == '0) && (last.rem_d == '0)))
        else $error("gcd does not divide the fraction");

    // A reduced denominator is never zero.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (last.action == ACT_REDUCE)) |-> (last.q_d != '0))
        else $error("reduced denominator is zero");

    // A stalled pipeline keeps its valid bits.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(dv_reg[W]) && $stable(gcd_valid)))
        else $error("pipeline moved during a stall");
`endif

endmodule

// ===== rtl/rrc_gcd.sv =====
module rrc_gcd
    import rrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      in_valid,
    input  gcd_item_t in_item,
    output logic      out_valid,
    output gcd_item_t out_item
);

    logic      valid_reg [NG];
    gcd_item_t item_reg  [NG];

    // Valid bits of the gcd stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NG; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < NG; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // One gcd step per stage.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg[0] <= gcd_step(in_item);
            for (int i = 1; i < NG; i++)
            begin
                item_reg[i] <= gcd_step(item_reg[i-1]);
            end
        end
    end

    assign out_valid = valid_reg[NG-1];
    assign out_item  = item_reg[NG-1];

`ifndef NO_ASSERTIONS
    // The pair must have run down to a zero by the last stage.
    a_gcd_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.u == '0) || (out_item.v == '0)))
        else $error("gcd not finished at pipeline end");

    // The denominator never reaches zero, so neither does the gcd.
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.u | out_item.v) != '0))
        else $error("gcd is zero");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rrc_pkg::*;

    // One fraction transaction and the result it should produce.
    typedef struct packed {
        logic          action;
        logic [W-1:0]  num_a;
        logic [W-2:0]  den_a;
        logic [W-1:0]  num_b;
        logic [W-2:0]  den_b;
    } frac_op_t;

    typedef struct packed {
        logic [W-1:0] reduced_num;
        logic [W-2:0] reduced_den;
        logic         is_greater;
        logic         is_equal;
    } frac_res_t;

    typedef struct packed {
        frac_op_t  op;
        logic      known;
        frac_res_t res;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;

    frac_res_t  pending_results[$];
    int         errors;
    int         cycle_count;
    bit         hold_off;
    bit         no_idle;

    rational_reduce_and_compare dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Euclid on magnitudes; the denominator is at least one, so this ends nonzero.
    function automatic longint unsigned euclid(input longint unsigned x,
                                               input longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Work out the exact result of one fraction transaction.
    function automatic frac_res_t fraction_result(input frac_op_t op);
        frac_res_t       r;
        longint          na;
        longint          nb;
        longint          da;
        longint          db;
        longint unsigned g;
        longint          rn;
        longint          rd;
        r  = '0;
        na = longint'($signed(op.num_a));
        nb = longint'($signed(op.num_b));
        da = (op.den_a == '0) ? 1 : longint'(op.den_a);
        db = (op.den_b == '0) ? 1 : longint'(op.den_b);
        if (op.action == ACT_REDUCE)
        begin
            g  = euclid((na < 0) ? -na : na, da);
            rn = na / longint'(g);
            rd = da / longint'(g);
            r.reduced_num = rn[W-1:0];
            r.reduced_den = rd[W-2:0];
        end
        else
        begin
            r.is_greater = (na * db) > (nb * da);
            r.is_equal   = (na * db) == (nb * da);
        end
        return r;
    endfunction

    function automatic stim_row_t row(input logic act, input logic [W-1:0] na,
                                      input logic [W-2:0] da, input logic [W-1:0] nb,
                                      input logic [W-2:0] db, input logic known,
                                      input frac_res_t res);
        stim_row_t s;
        s.op    = '{act, na, da, nb, db};
        s.known = known;
        s.res   = res;
        return s;
    endfunction

    // Random fraction: some small values with shared factors, mostly full range.
    function automatic frac_op_t random_op();
        frac_op_t op;
        int       f;
        int       sel;
        op.action = 1'($urandom_range(0, 1));
        sel       = $urandom_range(0, 9);
        if (sel < 4)
        begin
            f        = $urandom_range(1, 1000);
            op.num_a = W'($signed(f * ($urandom_range(0, 2000) - 1000)));
            op.den_a = (W-1)'(f * $urandom_range(0, 2000));
            op.num_b = W'($signed(f * ($urandom_range(0, 2000) - 1000)));
            op.den_b = (W-1)'(f * $urandom_range(0, 2000));
        end
        else
        begin
            op.num_a = $urandom;
            op.den_a = (W-1)'($urandom);
            op.num_b = $urandom;
            op.den_b = (W-1)'($urandom);
        end
        // Pairs scaled by a common factor, equal in value unless a product wraps, exercise the equal flag.
        if (sel == 9)
        begin
            f        = $urandom_range(1, 7);
            op.num_b = W'(op.num_a * f);
            op.den_b = (W-1)'(op.den_a * f);
            if (op.den_a == '0)
                op.den_b = (W-1)'(f);
        end
        // Values near the extremes.
        if (sel == 8)
        begin
            op.num_a = {1'b1, {(W-1){1'b0}}} + $urandom_range(0, 3);
            op.den_a = (W-1)'({(W-1){1'b1}} - $urandom_range(0, 3));
        end
        return op;
    endfunction

    // Offer one transaction, idling at random unless the quiet stretch is on.
    task automatic send_op(input frac_op_t op);
        while (!no_idle && $urandom_range(0, 99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op.action;
        s_tdata  <= IN_BITS'({op.den_b, op.num_b, op.den_a, op.num_a});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver side: random stalls plus a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else if (no_idle)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 15);
    end

    // Check each result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        frac_res_t want;
        frac_res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[W-1:0], m_tdata[2*W-2:W], m_tdata[2*W-1], m_tdata[2*W]};
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.reduced_num !== got.reduced_num)
                begin
                    errors++;
                    $display("%0t: reduced_num expected %h actual %h",
                             $time, want.reduced_num, got.reduced_num);
                end
                if (want.reduced_den !== got.reduced_den)
                begin
                    errors++;
                    $display("%0t: reduced_den expected %h actual %h",
                             $time, want.reduced_den, got.reduced_den);
                end
                if (want.is_greater !== got.is_greater)
                begin
                    errors++;
                    $display("%0t: is_greater expected %b actual %b",
                             $time, want.is_greater, got.is_greater);
                end
                if (want.is_equal !== got.is_equal)
                begin
                    errors++;
                    $display("%0t: is_equal expected %b actual %b",
                             $time, want.is_equal, got.is_equal);
                end
            end
        end
    end

    // Cycle limit for the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Queue the expectation at the accepting edge.
    task automatic push_expected(input frac_op_t op, input logic known,
                                 input frac_res_t res);
        frac_res_t p;
        p = fraction_result(op);
        if (known && p !== res)
        begin
            errors++;
            $display("%0t: table row expected %h predicted %h", $time, res, p);
        end
        pending_results.push_back(known ? res : p);
    endtask

    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-2:0] DMAX = {(W-1){1'b1}};

    initial
    begin
        stim_row_t table_rows[$];
        frac_op_t  op;
        int        n;
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        errors      = 0;
        cycle_count = 0;
        hold_off    = 1'b0;
        no_idle     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: extremes, zero numerator, zero denominator, both actions.
        table_rows.push_back(row(ACT_REDUCE, '0, '0, '0, '0, 1, '{'0, 1, 0, 0}));
        table_rows.push_back(row(ACT_REDUCE, '0, DMAX, '0, '0, 1, '{'0, 1, 0, 0}));
        table_rows.push_back(row(ACT_REDUCE, 6, 4, '0, '0, 1, '{3, 2, 0, 0}));
        table_rows.push_back(row(ACT_REDUCE, -6, 4, '0, '0, 1, '{-3, 2, 0, 0}));
        table_rows.push_back(row(ACT_REDUCE, 7, '0, '0, '0, 1, '{7, 1, 0, 0}));
        table_rows.push_back(row(ACT_REDUCE, MINN, 1, '0, '0, 1, '{MINN, 1, 0, 0}));
        table_rows.push_back(row(ACT_REDUCE, MINN, '0, '0, '0, 1, '{MINN, 1, 0, 0}));
        table_rows.push_back(row(ACT_REDUCE, MINN, 2, '0, '0, 0, '0));
        table_rows.push_back(row(ACT_REDUCE, MINN, DMAX, '0, '0, 0, '0));
        table_rows.push_back(row(ACT_REDUCE, MAXP, DMAX, '0, '0, 1, '{1, 1, 0, 0}));
        table_rows.push_back(row(ACT_REDUCE, -MAXP, 1, '0, '0, 1, '{-MAXP, 1, 0, 0}));
        table_rows.push_back(row(ACT_REDUCE, 1024, 4096, '0, '0, 1, '{1, 4, 0, 0}));
        table_rows.push_back(row(ACT_COMPARE, 1, 2, 1, 3, 1, '{'0, '0, 1, 0}));
        table_rows.push_back(row(ACT_COMPARE, 1, 3, 1, 2, 1, '{'0, '0, 0, 0}));
        table_rows.push_back(row(ACT_COMPARE, 2, 4, 1, 2, 1, '{'0, '0, 0, 1}));
        table_rows.push_back(row(ACT_COMPARE, 5, '0, 5, 1, 1, '{'0, '0, 0, 1}));
        table_rows.push_back(row(ACT_COMPARE, '0, '0, '0, DMAX, 1, '{'0, '0, 0, 1}));
        table_rows.push_back(row(ACT_COMPARE, MAXP, 1, MINN, 1, 1, '{'0, '0, 1, 0}));
        table_rows.push_back(row(ACT_COMPARE, MINN, 1, MAXP, 1, 1, '{'0, '0, 0, 0}));
        table_rows.push_back(row(ACT_COMPARE, MAXP, DMAX, MAXP, DMAX, 1, '{'0, '0, 0, 1}));
        table_rows.push_back(row(ACT_COMPARE, MINN, DMAX, -1, 1, 0, '0));
        table_rows.push_back(row(ACT_COMPARE, -1, 1, -2, 1, 1, '{'0, '0, 1, 0}));
        table_rows.push_back(row(ACT_COMPARE, MAXP, DMAX, MINN, DMAX, 0, '0));

        @(negedge clk);
        foreach (table_rows[i])
        begin
            fork
                send_op(table_rows[i].op);
                begin
                    @(posedge clk);
                    while (!(s_tvalid && s_tready))
                        @(posedge clk);
                    push_expected(table_rows[i].op, table_rows[i].known,
                                  table_rows[i].res);
                end
            join
        end

        // Random traffic, with a receiver hold-off, a quiet stretch and a drain pause.
        for (n = 0; n < 1600; n++)
        begin
            if (n == 300)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            no_idle = (n >= 700 && n < 950);
            if (n == 1200)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            op = random_op();
            fork
                send_op(op);
                begin
                    @(posedge clk);
                    while (!(s_tvalid && s_tready))
                        @(posedge clk);
                    push_expected(op, 1'b0, '0);
                end
            join
        end
        no_idle  = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== rational_reduce_and_compare.f =====
rtl/rrc_pkg.sv
rtl/rrc_gcd.sv
rtl/rational_reduce_and_compare.sv
tb/tb.sv
